// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define MM3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define MM3_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/mm3_pkg.sv =====
package mm3_pkg;

	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
	localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
	localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

	// Work handed from the byte packer to the hash core.
	typedef enum logic [1:0] {
		CMD_MIX      = 2'd0,  // mix a full word, message goes on
		CMD_MIX_FIN  = 2'd1,  // mix a full word, then finalize without a tail
		CMD_TAIL_FIN = 2'd2,  // scramble the partial tail word, then finalize
		CMD_EMPTY    = 2'd3   // zero-length message
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] word;
		logic [31:0] length;
	} cmd_t;

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] x);
		return {x[18:0], x[31:19]};
	endfunction

endpackage

// ===== design/murmur3_32_byte_stream_hash_unit.sv =====
// MurmurHash3 x86 32-bit (seed zero) over a byte stream, one byte per beat.
// Push bytes in string order; mark the final byte with last, and one hash
// beat comes out for that message. A beat with empty_req set ignores the
// byte, drops any message in progress and yields the empty-message hash (0).
// Tail bytes are unsigned; the byte count wraps modulo 2^32. A byte packer
// takes one beat per cycle while the command queue is not full and hands
// full words and finalize requests through a four-entry command queue to
// the hash core. The core takes each full word through pickup, two multiply
// steps of the word scramble and a hash update, which keeps pace with one
// byte per cycle. A last byte leaving a partial tail goes through pickup,
// two scramble steps, two avalanche multiply steps and the result write; a
// last byte completing a word adds the hash update, and an empty request
// goes from pickup straight to the result write. A two-entry result queue
// holds hashes until they are popped, and the core holds its result while
// that queue is full. full rises only when the command queue backs up.
module murmur3_32_byte_stream_hash_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic        empty_req,
	output logic [31:0] hash_value,
	output logic        empty,
	input  logic        pop
);

	// Packer side: words and finalize requests into the queue.
	mm3_pkg::cmd_t wr_cmd;
	logic          wr_en;
	logic          q_full;

	// Core side: oldest request out of the queue.
	mm3_pkg::cmd_t rd_cmd;
	logic          rd_en;
	logic          q_empty;

	assign full = q_full;

	mm3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.last      (last),
		.empty_req (empty_req),
		.q_full    (q_full),
		.cmd_push  (wr_en),
		.cmd       (wr_cmd)
	);

	mm3_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_cmd (wr_cmd),
		.full   (q_full),
		.rd_en  (rd_en),
		.rd_cmd (rd_cmd),
		.empty  (q_empty)
	);

	mm3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (rd_cmd),
		.cmd_empty  (q_empty),
		.cmd_pop    (rd_en),
		.hash_value (hash_value),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ===== design/mm3_front.sv =====
module mm3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        data_byte,
	input  logic              last,
	input  logic              empty_req,
	input  logic              q_full,
	output logic              cmd_push,
	output mm3_pkg::cmd_t     cmd
);

	logic [23:0] pend_q;
	logic [1:0]  pos_q;
	logic [31:0] len_q;

	logic        acc;
	logic [31:0] len_inc;
	logic [23:0] pend_new;

	assign acc      = push && !q_full;
	assign len_inc  = len_q + 32'd1;
	assign pend_new = pend_q | ({16'd0, data_byte} << {pos_q, 3'b000});

	always_comb begin
		cmd_push    = 1'b0;
		cmd.kind    = mm3_pkg::CMD_MIX;
		cmd.word    = {data_byte, pend_q};
		cmd.length  = len_inc;
		if (acc) begin
			if (empty_req) begin
				cmd_push   = 1'b1;
				cmd.kind   = mm3_pkg::CMD_EMPTY;
				cmd.length = 32'd0;
			end else if (pos_q == 2'd3) begin
				cmd_push = 1'b1;
				cmd.kind = last ? mm3_pkg::CMD_MIX_FIN : mm3_pkg::CMD_MIX;
			end else if (last) begin
				cmd_push = 1'b1;
				cmd.kind = mm3_pkg::CMD_TAIL_FIN;
				cmd.word = {8'd0, pend_new};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pos_q  <= '0;
			len_q  <= '0;
		end else if (acc) begin
			if (empty_req || last) begin
				pend_q <= '0;
				pos_q  <= '0;
				len_q  <= '0;
			end else if (pos_q == 2'd3) begin
				pend_q <= '0;
				pos_q  <= '0;
				len_q  <= len_inc;
			end else begin
				pend_q <= pend_new;
				pos_q  <= pos_q + 2'd1;
				len_q  <= len_inc;
			end
		end
	end

endmodule

// ===== design/mm3_cmdq.sv =====
module mm3_cmdq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  mm3_pkg::cmd_t     wr_cmd,
	output logic              full,
	input  logic              rd_en,
	output mm3_pkg::cmd_t     rd_cmd,
	output logic              empty
);

	mm3_pkg::cmd_t                 mem_q [mm3_pkg::CMDQ_DEPTH];
	logic [mm3_pkg::CMDQ_AW-1:0]   wr_ptr_q;
	logic [mm3_pkg::CMDQ_AW-1:0]   rd_ptr_q;
	logic [mm3_pkg::CMDQ_CW-1:0]   count_q;

	logic do_wr;
	logic do_rd;

	assign full   = (count_q == mm3_pkg::CMDQ_CW'(mm3_pkg::CMDQ_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + mm3_pkg::CMDQ_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + mm3_pkg::CMDQ_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + mm3_pkg::CMDQ_CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - mm3_pkg::CMDQ_CW'(1);
			end
		end
	end

endmodule

// ===== design/mm3_back.sv =====
module mm3_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mm3_pkg::cmd_t     cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output logic [31:0]       hash_value,
	output logic              empty,
	input  logic              pop
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SC1  = 7'b0000010,
		ST_SC2  = 7'b0000100,
		ST_HMIX = 7'b0001000,
		ST_FX   = 7'b0010000,
		ST_FM   = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t               state_q;
	mm3_pkg::cmd_kind_t   kind_q;
	logic [31:0]          k_q;
	logic [31:0]          h_q;
	logic [31:0]          len_q;

	logic [31:0]                 res_mem_q [mm3_pkg::RESQ_DEPTH];
	logic [mm3_pkg::RESQ_AW-1:0] res_wr_q;
	logic [mm3_pkg::RESQ_AW-1:0] res_rd_q;
	logic [mm3_pkg::RESQ_CW-1:0] res_cnt_q;

	logic        res_full;
	logic        res_wr;
	logic        res_rd;
	logic [31:0] rot_h;
	logic [31:0] fin_t;
	logic [31:0] fin_x;
	logic [31:0] res_val;

	assign res_full   = (res_cnt_q == mm3_pkg::RESQ_CW'(mm3_pkg::RESQ_DEPTH));
	assign empty      = (res_cnt_q == '0);
	assign hash_value = res_mem_q[res_rd_q];
	assign res_wr     = (state_q == ST_OUT) && !res_full;
	assign res_rd     = pop && !empty;
	assign cmd_pop    = (state_q == ST_IDLE) && !cmd_empty;

	assign rot_h   = mm3_pkg::rotl13(h_q ^ k_q);
	assign fin_t   = h_q ^ k_q ^ len_q;
	assign fin_x   = fin_t ^ (fin_t >> 16);
	assign res_val = k_q ^ (k_q >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= mm3_pkg::CMD_MIX;
			k_q     <= '0;
			h_q     <= '0;
			len_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						kind_q <= cmd.kind;
						len_q  <= cmd.length;
						if (cmd.kind == mm3_pkg::CMD_EMPTY) begin
							k_q     <= '0;
							h_q     <= '0;
							state_q <= ST_OUT;
						end else begin
							k_q     <= cmd.word;
							state_q <= ST_SC1;
						end
					end
				end
				ST_SC1: begin
					k_q     <= k_q * mm3_pkg::MIX_C1;
					state_q <= ST_SC2;
				end
				ST_SC2: begin
					k_q     <= mm3_pkg::rotl15(k_q) * mm3_pkg::MIX_C2;
					state_q <= (kind_q == mm3_pkg::CMD_TAIL_FIN) ? ST_FX : ST_HMIX;
				end
				ST_HMIX: begin
					h_q <= (rot_h << 2) + rot_h + mm3_pkg::MIX_ADD;
					k_q <= '0;
					state_q <= (kind_q == mm3_pkg::CMD_MIX_FIN) ? ST_FX : ST_IDLE;
				end
				ST_FX: begin
					k_q     <= fin_x * mm3_pkg::FIN_C1;
					h_q     <= '0;
					state_q <= ST_FM;
				end
				ST_FM: begin
					k_q     <= (k_q ^ (k_q >> 13)) * mm3_pkg::FIN_C2;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_mem_q[res_wr_q] <= res_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_wr) begin
				res_wr_q <= res_wr_q + mm3_pkg::RESQ_AW'(1);
			end
			if (res_rd) begin
				res_rd_q <= res_rd_q + mm3_pkg::RESQ_AW'(1);
			end
			if (res_wr && !res_rd) begin
				res_cnt_q <= res_cnt_q + mm3_pkg::RESQ_CW'(1);
			end else if (res_rd && !res_wr) begin
				res_cnt_q <= res_cnt_q - mm3_pkg::RESQ_CW'(1);
			end
		end
	end

endmodule

// ===== design/mm3_chk.sv =====
`include "assert_macros.svh"

module mm3_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [7:0]  data_byte,
	input logic        last,
	input logic        empty_req,
	input logic [31:0] hash_value,
	input logic        empty,
	input logic        pop
);

	// Both queues come out of reset drained.
	`MM3_ASSERT_ALWAYS(a_reset_drained, (!arst_n) |-> (empty && !full), "queues not drained in reset")

	// A waiting result beat holds until popped.
	`MM3_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(hash_value)), "result beat changed")

	// Backpressure only builds up behind an accepted byte beat.
	`MM3_ASSERT(a_full_cause, $rose(full) |-> $past(push && !full), "full rose without an accepted beat")

endmodule

bind murmur3_32_byte_stream_hash_unit mm3_chk u_mm3_chk (.*);
